// File: rtl/ipv4_rx_filter_reassembly_tracker_defines.svh
`ifndef IPV4_RX_FILTER_REASSEMBLY_TRACKER_DEFINES_SVH
`define IPV4_RX_FILTER_REASSEMBLY_TRACKER_DEFINES_SVH

// same-cycle implication
`define IPRX_ASSERT_IMP(lbl, c, r, ante, cons) \
    lbl: assert property (@(posedge c) disable iff (!r) (ante) |-> (cons)) \
        else $error("iprx check failed");

// next-cycle implication
`define IPRX_ASSERT_NXT(lbl, c, r, ante, cons) \
    lbl: assert property (@(posedge c) disable iff (!r) (ante) |=> (cons)) \
        else $error("iprx check failed");

`endif

// File: rtl/iprx_pkg.sv
`timescale 1ns / 1ps

package iprx_pkg;

    localparam int SLOT_COUNT_DEF   = 256;
    localparam int MAX_DATAGRAM_DEF = 65536;
    localparam int HASH_RANGE       = 256;
    localparam int CFG_AW           = 4;

    localparam logic [7:0] HASH_SEED     = 8'h1d;
    localparam logic [7:0] UDP_PROTOCOL  = 8'd17;
    localparam logic [7:0] IPIP_PROTOCOL = 8'd4;

    localparam logic [1:0] REG_LOCAL_ADDR  = 2'd0;
    localparam logic [1:0] REG_PEER_ADDR   = 2'd1;
    localparam logic [1:0] REG_LOCAL_TUNL  = 2'd2;
    localparam logic [1:0] REG_PEER_TUNL   = 2'd3;

    localparam logic [3:0] ST_BAD_LEN      = 4'd0;
    localparam logic [3:0] ST_BAD_CKSUM    = 4'd1;
    localparam logic [3:0] ST_ADDR_MISS    = 4'd2;
    localparam logic [3:0] ST_OVERSIZE     = 4'd3;
    localparam logic [3:0] ST_FRAG_STORED  = 4'd4;
    localparam logic [3:0] ST_UDP_WHOLE    = 4'd5;
    localparam logic [3:0] ST_UDP_REASM    = 4'd6;
    localparam logic [3:0] ST_IPIP         = 4'd7;
    localparam logic [3:0] ST_OTHER_REASM  = 4'd8;
    localparam logic [3:0] ST_IGNORED      = 4'd9;

    typedef struct packed {
        logic [7:0]  version_ihl;
        logic [7:0]  type_of_service;
        logic [15:0] total_length;
        logic [15:0] identification;
        logic [15:0] flags_fragment;
        logic [7:0]  time_to_live;
        logic [7:0]  protocol_number;
        logic [15:0] header_checksum;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] frame_length;
        logic        inner_packet;
    } iprx_hdr_t;

    typedef struct packed {
        logic [3:0]  status;
        logic [7:0]  slot_index;
        logic [5:0]  payload_offset;
        logic [15:0] deliver_length;
    } iprx_res_t;

    typedef struct packed {
        logic [31:0] local_addr;
        logic [31:0] peer_addr;
        logic [31:0] local_tunnel_addr;
        logic [31:0] peer_tunnel_addr;
    } iprx_cfg_t;

    typedef struct packed {
        logic        len_ok;
        logic        cksum_ok;
        logic        addr_ok;
        logic        frag;
        logic        more;
        logic        is_udp;
        logic        is_ipip;
        logic [5:0]  hlen;
        logic [15:0] plen;
        logic [15:0] off;
    } iprx_chk_t;

    typedef struct packed {
        logic [15:0] received;
        logic [15:0] expected;
    } iprx_slot_t;

    function automatic logic [7:0] fold8(input logic [31:0] a);
        return a[31:24] ^ a[23:16] ^ a[15:8] ^ a[7:0];
    endfunction

    function automatic logic [7:0] slot_hash(input iprx_hdr_t h);
        return HASH_SEED ^ fold8(h.src_addr) ^ fold8(h.dst_addr)
             ^ h.identification[15:8] ^ h.identification[7:0];
    endfunction

endpackage

// File: rtl/iprx_if.sv
`timescale 1ns / 1ps

interface iprx_hdr_if import iprx_pkg::*; ();
    logic      valid;
    logic      ready;
    iprx_hdr_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface iprx_res_if import iprx_pkg::*; ();
    logic      valid;
    logic      ready;
    iprx_res_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/iprx_hdr_check.sv
`timescale 1ns / 1ps

module iprx_hdr_check import iprx_pkg::*;
(
    input  iprx_hdr_t hdr,
    input  iprx_cfg_t cfg,
    output iprx_chk_t chk
);

    logic [19:0] ck_sum;
    logic [16:0] ck_f1;
    logic [15:0] ck_f2;
    logic [5:0]  hlen;
    logic [15:0] off;

    assign hlen = {hdr.version_ihl[3:0], 2'b00};
    assign off  = {hdr.flags_fragment[12:0], 3'b000};

    // ones-complement sum over the fixed header words
    assign ck_sum = {4'd0, hdr.version_ihl, hdr.type_of_service}
                  + {4'd0, hdr.total_length}
                  + {4'd0, hdr.identification}
                  + {4'd0, hdr.flags_fragment}
                  + {4'd0, hdr.time_to_live, hdr.protocol_number}
                  + {4'd0, hdr.src_addr[31:16]}
                  + {4'd0, hdr.src_addr[15:0]}
                  + {4'd0, hdr.dst_addr[31:16]}
                  + {4'd0, hdr.dst_addr[15:0]};
    assign ck_f1 = {1'b0, ck_sum[15:0]} + {13'd0, ck_sum[19:16]};
    assign ck_f2 = ck_f1[15:0] + {15'd0, ck_f1[16]};

    always_comb
    begin
        chk.len_ok     = hdr.frame_length == hdr.total_length;
        chk.cksum_ok   = ~ck_f2 == hdr.header_checksum;
        chk.addr_ok    = hdr.inner_packet
                       ? (hdr.dst_addr == cfg.local_tunnel_addr
                          && hdr.src_addr == cfg.peer_tunnel_addr)
                       : (hdr.dst_addr == cfg.local_addr
                          && hdr.src_addr == cfg.peer_addr);
        chk.more       = hdr.flags_fragment[13];
        chk.frag       = hdr.flags_fragment[13] || (off != 16'd0);
        chk.is_udp     = hdr.protocol_number == UDP_PROTOCOL;
        chk.is_ipip    = hdr.protocol_number == IPIP_PROTOCOL;
        chk.hlen       = hlen;
        chk.plen       = hdr.total_length - {10'd0, hlen};
        chk.off        = off;
    end

endmodule

// File: rtl/iprx_slot_mem.sv
`timescale 1ns / 1ps

module iprx_slot_mem import iprx_pkg::*;
#(
    parameter int DEPTH = SLOT_COUNT_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output iprx_slot_t               rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  iprx_slot_t               wr_data
);

    iprx_slot_t       slot_mem_reg [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    iprx_slot_t       rd_word_reg;
    logic             rd_hit_reg;
    logic             same_addr;

    assign same_addr = wr_en && (wr_addr == rd_addr);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_mem_reg[wr_addr] <= wr_data;
        end
    end

    // read with write bypass
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (same_addr)
            begin
                rd_word_reg <= wr_data;
            end
            else
            begin
                rd_word_reg <= slot_mem_reg[rd_addr];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_hit_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_hit_reg <= same_addr || valid_reg[rd_addr];
            end
        end
    end

    // untouched slots read as zero
    assign rd_data = rd_hit_reg ? rd_word_reg : '0;

endmodule

// File: rtl/ipv4_rx_filter_reassembly_tracker.sv
`timescale 1ns / 1ps
// channel  dir  payload     transfer when
// hdr      in   iprx_hdr_t  hdr.valid && hdr.ready
// res      out  iprx_res_t  res.valid && res.ready
// apb      in   32-bit reg  psel && penable && pwrite
//
// one header accepted per cycle while res does not stall
// registered slot read feeds one read-modify-write stage, then the result register
// a write to the same slot in the stage ahead is forwarded into the read
// reset clears config, slot valid bits and both valid flags at once, no sweep
// res stall holds the result register, the check stage and then hdr.ready

`include "ipv4_rx_filter_reassembly_tracker_defines.svh"

module ipv4_rx_filter_reassembly_tracker import iprx_pkg::*;
#(
    parameter int SLOT_COUNT   = SLOT_COUNT_DEF,
    parameter int MAX_DATAGRAM = MAX_DATAGRAM_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    iprx_hdr_if.sink          hdr,
    iprx_res_if.source        res
);

    localparam int DEPTH  = (SLOT_COUNT < HASH_RANGE) ? SLOT_COUNT : HASH_RANGE;
    localparam int SLOT_W = $clog2(DEPTH);
    localparam logic [16:0] MAX_DG = 17'(MAX_DATAGRAM);

    iprx_cfg_t   cfg_reg;
    iprx_hdr_t   s1_hdr_reg;
    logic [SLOT_W-1:0] s1_slot_reg;
    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic        s1_adv;
    logic        in_xfer;
    iprx_res_t   res_reg;
    iprx_res_t   res_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    iprx_chk_t   chk;
    iprx_slot_t  slot_rd;
    iprx_slot_t  slot_wr;
    logic        mem_we;
    logic [SLOT_W-1:0] in_slot;
    logic [SLOT_W-1:0] slot_lut [HASH_RANGE];
    logic [16:0] reach;
    logic        oversize;
    logic [15:0] rcv_new;
    logic [15:0] exp_cut;
    logic [15:0] exp_new;
    logic        complete;
    logic        res_slot_set;
    logic        res_slot_ok;
    logic        res_len_set;
    logic        res_len_ok;

    // hash to slot reduction table
    for (genvar g = 0; g < HASH_RANGE; g++)
    begin : g_lut
        localparam int unsigned SLOT_G = g % SLOT_COUNT;
        assign slot_lut[g] = SLOT_W'(SLOT_G);
    end

    assign in_slot = slot_lut[slot_hash(hdr.data)];

    // configuration port
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[3:2])
                REG_LOCAL_ADDR: cfg_reg.local_addr        <= pwdata;
                REG_PEER_ADDR:  cfg_reg.peer_addr         <= pwdata;
                REG_LOCAL_TUNL: cfg_reg.local_tunnel_addr <= pwdata;
                REG_PEER_TUNL:  cfg_reg.peer_tunnel_addr  <= pwdata;
                default:        cfg_reg.local_addr        <= cfg_reg.local_addr;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_LOCAL_ADDR: prdata = cfg_reg.local_addr;
            REG_PEER_ADDR:  prdata = cfg_reg.peer_addr;
            REG_LOCAL_TUNL: prdata = cfg_reg.local_tunnel_addr;
            REG_PEER_TUNL:  prdata = cfg_reg.peer_tunnel_addr;
            default:        prdata = '0;
        endcase
    end

    // handshake
    assign s1_adv    = s1_valid_reg && (!out_valid_reg || res.ready);
    assign hdr.ready = !s1_valid_reg || s1_adv;
    assign in_xfer   = hdr.valid && hdr.ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_xfer)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (s1_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_hdr_reg  <= hdr.data;
            s1_slot_reg <= in_slot;
        end
        if (s1_adv)
        begin
            res_reg <= res_next;
        end
    end

    iprx_hdr_check u_check
    (
        .hdr (s1_hdr_reg),
        .cfg (cfg_reg),
        .chk (chk)
    );

    iprx_slot_mem #(
        .DEPTH (DEPTH)
    ) u_slot_mem
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (in_xfer),
        .rd_addr (in_slot),
        .rd_data (slot_rd),
        .wr_en   (mem_we),
        .wr_addr (s1_slot_reg),
        .wr_data (slot_wr)
    );

    // fragment bookkeeping
    assign reach    = {1'b0, chk.plen} + {1'b0, chk.off};
    assign oversize = reach >= MAX_DG;
    assign rcv_new  = slot_rd.received + chk.plen;
    assign exp_cut  = (slot_rd.expected != 16'd0 && chk.off > slot_rd.expected)
                    ? 16'd0 : slot_rd.expected;
    assign exp_new  = chk.more ? exp_cut : reach[15:0];
    assign complete = rcv_new == exp_new;

    assign mem_we = s1_adv && chk.len_ok && chk.cksum_ok && chk.addr_ok
                  && chk.frag && !oversize;

    always_comb
    begin
        slot_wr.received = complete ? 16'd0 : rcv_new;
        slot_wr.expected = complete ? 16'd0 : exp_new;
    end

    always_comb
    begin
        res_next.status         = ST_IGNORED;
        res_next.slot_index     = 8'd0;
        res_next.payload_offset = chk.hlen;
        res_next.deliver_length = 16'd0;
        if (!chk.len_ok)
        begin
            res_next.status = ST_BAD_LEN;
        end
        else if (!chk.cksum_ok)
        begin
            res_next.status = ST_BAD_CKSUM;
        end
        else if (!chk.addr_ok)
        begin
            res_next.status = ST_ADDR_MISS;
        end
        else if (chk.frag)
        begin
            res_next.slot_index = 8'(s1_slot_reg);
            if (oversize)
            begin
                res_next.status = ST_OVERSIZE;
            end
            else if (complete)
            begin
                res_next.status         = chk.is_udp ? ST_UDP_REASM : ST_OTHER_REASM;
                res_next.deliver_length = exp_new;
            end
            else
            begin
                res_next.status = ST_FRAG_STORED;
            end
        end
        else if (chk.is_udp)
        begin
            res_next.status         = ST_UDP_WHOLE;
            res_next.deliver_length = chk.plen;
        end
        else if (chk.is_ipip)
        begin
            res_next.status         = ST_IPIP;
            res_next.deliver_length = chk.plen;
        end
        else
        begin
            res_next.status = ST_IGNORED;
        end
    end

    assign res.valid = out_valid_reg;
    assign res.data  = res_reg;

    assign res_slot_set = res.valid && res.data.slot_index != 8'd0;
    assign res_slot_ok  = res.data.status == ST_OVERSIZE || res.data.status == ST_FRAG_STORED
                       || res.data.status == ST_UDP_REASM || res.data.status == ST_OTHER_REASM;
    assign res_len_set  = res.valid && res.data.deliver_length != 16'd0;
    assign res_len_ok   = res.data.status == ST_UDP_WHOLE || res.data.status == ST_UDP_REASM
                       || res.data.status == ST_IPIP || res.data.status == ST_OTHER_REASM;

    `IPRX_ASSERT_IMP(a_we_on_adv, clk, rst_n, mem_we, s1_adv && s1_valid_reg)
    `IPRX_ASSERT_NXT(a_accept_fills, clk, rst_n, in_xfer, s1_valid_reg)
    `IPRX_ASSERT_IMP(a_slot_only_frag, clk, rst_n, res_slot_set, res_slot_ok)
    `IPRX_ASSERT_IMP(a_len_only_deliver, clk, rst_n, res_len_set, res_len_ok)

endmodule

// File: bench/ipv4_rx_filter_reassembly_tracker_test.sv
`timescale 1ns / 1ps

module ipv4_rx_filter_reassembly_tracker_test;
    import iprx_pkg::*;

    localparam int HALF_PERIOD = 6;
    localparam int QUIET_LIMIT = 2000;
    localparam int LONG_HOLD   = 300;
    localparam int MF_BIT      = 13;
    localparam logic [15:0] MF_MASK = 16'h2000;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [CFG_AW-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    iprx_hdr_if hdr_ch ();
    iprx_res_if res_ch ();

    ipv4_rx_filter_reassembly_tracker uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .hdr     (hdr_ch),
        .res     (res_ch)
    );

    logic [31:0] cfg_local      = '0;
    logic [31:0] cfg_peer       = '0;
    logic [31:0] cfg_local_tunl = '0;
    logic [31:0] cfg_peer_tunl  = '0;

    logic [15:0] slot_received [SLOT_COUNT_DEF] = '{default: 16'h0};
    logic [15:0] slot_expected [SLOT_COUNT_DEF] = '{default: 16'h0};

    iprx_res_t pending_results[$];
    int        error_count  = 0;
    int        items_sent   = 0;
    bit        tx_idle_on   = 1'b1;
    bit        rx_idle_on   = 1'b1;
    bit        hold_request = 1'b0;

    initial clk = 1'b0;
    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    function automatic logic [15:0] header_checksum_of(input iprx_hdr_t h);
        logic [15:0] words [9];
        logic [31:0] acc;
        words[0] = {h.version_ihl, h.type_of_service};
        words[1] = h.total_length;
        words[2] = h.identification;
        words[3] = h.flags_fragment;
        words[4] = {h.time_to_live, h.protocol_number};
        words[5] = h.src_addr[31:16];
        words[6] = h.src_addr[15:0];
        words[7] = h.dst_addr[31:16];
        words[8] = h.dst_addr[15:0];
        acc = '0;
        foreach (words[i])
        begin
            acc = acc + words[i];
            acc = {16'h0, acc[15:0]} + {16'h0, acc[31:16]};
        end
        return ~acc[15:0];
    endfunction

    function automatic logic [7:0] slot_of(input iprx_hdr_t h);
        logic [7:0] x;
        x = HASH_SEED ^ h.identification[15:8] ^ h.identification[7:0];
        for (int b = 0; b < 4; b++)
            x = x ^ h.src_addr[8*b +: 8] ^ h.dst_addr[8*b +: 8];
        return 8'(x % SLOT_COUNT_DEF);
    endfunction

    // filter checks, then per-slot fragment accounting
    function automatic iprx_res_t track_header(input iprx_hdr_t h);
        iprx_res_t   r;
        logic [5:0]  hlen;
        logic [15:0] plen;
        logic [15:0] off;
        logic        more;
        logic        addr_ok;
        logic [7:0]  slot;
        r = '0;
        hlen = {h.version_ihl[3:0], 2'b00};
        plen = h.total_length - 16'(hlen);
        off = {h.flags_fragment[12:0], 3'b000};
        more = h.flags_fragment[MF_BIT];
        addr_ok = h.inner_packet ?
                  (h.dst_addr == cfg_local_tunl && h.src_addr == cfg_peer_tunl) :
                  (h.dst_addr == cfg_local && h.src_addr == cfg_peer);
        r.payload_offset = hlen;
        if (h.frame_length != h.total_length)
            r.status = ST_BAD_LEN;
        else if (header_checksum_of(h) != h.header_checksum)
            r.status = ST_BAD_CKSUM;
        else if (!addr_ok)
            r.status = ST_ADDR_MISS;
        else if (more || off != 16'h0)
        begin
            slot = slot_of(h);
            r.slot_index = slot;
            if (int'(plen) + int'(off) >= MAX_DATAGRAM_DEF)
                r.status = ST_OVERSIZE;
            else
            begin
                slot_received[slot] = slot_received[slot] + plen;
                if (slot_expected[slot] != 16'h0 && off > slot_expected[slot])
                    slot_expected[slot] = 16'h0;
                if (!more)
                    slot_expected[slot] = off + plen;
                if (slot_received[slot] == slot_expected[slot])
                begin
                    r.status = (h.protocol_number == UDP_PROTOCOL) ? ST_UDP_REASM
                                                                   : ST_OTHER_REASM;
                    r.deliver_length = slot_expected[slot];
                    slot_expected[slot] = 16'h0;
                    slot_received[slot] = 16'h0;
                end
                else
                    r.status = ST_FRAG_STORED;
            end
        end
        else if (h.protocol_number == UDP_PROTOCOL)
        begin
            r.status = ST_UDP_WHOLE;
            r.deliver_length = plen;
        end
        else if (h.protocol_number == IPIP_PROTOCOL)
        begin
            r.status = ST_IPIP;
            r.deliver_length = plen;
        end
        else
            r.status = ST_IGNORED;
        return r;
    endfunction

    function automatic iprx_hdr_t build_header(input bit inner, input logic [15:0] ident,
                                               input logic [15:0] ff, input logic [7:0] proto,
                                               input logic [3:0] ihl, input logic [15:0] plen);
        iprx_hdr_t h;
        h.version_ihl = {($urandom_range(0, 7) == 0) ? 4'($urandom) : 4'd4, ihl};
        h.type_of_service = 8'($urandom);
        h.total_length = {10'h0, ihl, 2'b00} + plen;
        h.identification = ident;
        h.flags_fragment = ff;
        h.time_to_live = 8'($urandom);
        h.protocol_number = proto;
        h.src_addr = inner ? cfg_peer_tunl : cfg_peer;
        h.dst_addr = inner ? cfg_local_tunl : cfg_local;
        h.frame_length = h.total_length;
        h.inner_packet = inner;
        h.header_checksum = header_checksum_of(h);
        return h;
    endfunction

    function automatic iprx_hdr_t damage(input iprx_hdr_t h);
        case ($urandom_range(0, 4))
            0: h.frame_length = h.frame_length ^ 16'($urandom_range(1, 65535));
            1: h.header_checksum = h.header_checksum ^ 16'($urandom_range(1, 65535));
            2: h.src_addr = h.src_addr ^ (32'd1 << $urandom_range(0, 31));
            3: h.dst_addr = h.dst_addr ^ (32'd1 << $urandom_range(0, 31));
            default: h.inner_packet = ~h.inner_packet;
        endcase
        if (!h.inner_packet || $urandom_range(0, 1) == 0)
            return h;
        return h;
    endfunction

    function automatic iprx_hdr_t noise_header();
        logic [191:0] bits;
        iprx_hdr_t    h;
        bits = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        h = bits[$bits(iprx_hdr_t)-1:0];
        if ($urandom_range(0, 3) != 0)
            h.frame_length = h.total_length;
        if ($urandom_range(0, 2) != 0)
        begin
            if ($urandom_range(0, 1) == 0)
            begin
                h.src_addr = h.inner_packet ? cfg_peer_tunl : cfg_peer;
                h.dst_addr = h.inner_packet ? cfg_local_tunl : cfg_local;
            end
            h.header_checksum = header_checksum_of(h);
        end
        return h;
    endfunction

    function automatic logic [7:0] pick_protocol();
        case ($urandom_range(0, 4))
            0, 1: return UDP_PROTOCOL;
            2: return IPIP_PROTOCOL;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic match_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            error_count++;
        end
    endtask

    task automatic check_result(input iprx_res_t got);
        iprx_res_t want;
        if (pending_results.size() == 0)
        begin
            $display("%0t: unexpected result, expected none, actual %0h", $time, got);
            error_count++;
        end
        else
        begin
            want = pending_results.pop_front();
            match_field("status", want.status, got.status);
            match_field("slot_index", want.slot_index, got.slot_index);
            match_field("payload_offset", want.payload_offset, got.payload_offset);
            match_field("deliver_length", want.deliver_length, got.deliver_length);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && hdr_ch.valid && hdr_ch.ready)
            pending_results.push_back(track_header(hdr_ch.data));
        if (rst_n && res_ch.valid && res_ch.ready)
            check_result(res_ch.data);
    end

    initial
    begin
        int hold_left;
        hold_left = 0;
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_left = LONG_HOLD;
                hold_request = 1'b0;
            end
            else if (hold_left == 0 && rx_idle_on && $urandom_range(0, 4) == 0)
                hold_left = $urandom_range(1, 11);
            if (hold_left > 0)
            begin
                res_ch.ready = 1'b0;
                hold_left--;
            end
            else
                res_ch.ready = 1'b1;
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (hdr_ch.valid && hdr_ch.ready) || (res_ch.valid && res_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
        $display("ipv4_rx_filter_reassembly_tracker verification failed");
        $finish;
    end

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_header(input iprx_hdr_t h);
        if (tx_idle_on && $urandom_range(0, 3) == 0)
        begin
            hdr_ch.valid = 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        hdr_ch.valid = 1'b1;
        hdr_ch.data = h;
        do @(posedge clk); while (!hdr_ch.ready);
        @(negedge clk);
        items_sent++;
    endtask

    task automatic wait_drained();
        hdr_ch.valid = 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_register(input logic [1:0] index, input logic [31:0] value);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = {index, 2'b00};
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        match_field("prdata", value, prdata);
        case (index)
            REG_LOCAL_ADDR: cfg_local = value;
            REG_PEER_ADDR:  cfg_peer = value;
            REG_LOCAL_TUNL: cfg_local_tunl = value;
            REG_PEER_TUNL:  cfg_peer_tunl = value;
            default: ;
        endcase
    endtask

    task automatic set_addresses(input logic [31:0] local_a, input logic [31:0] peer_a,
                                 input logic [31:0] local_t, input logic [31:0] peer_t);
        wait_drained();
        write_register(REG_LOCAL_ADDR, local_a);
        write_register(REG_PEER_ADDR, peer_a);
        write_register(REG_LOCAL_TUNL, local_t);
        write_register(REG_PEER_TUNL, peer_t);
    endtask

    // one datagram cut into fragments, sometimes reordered, short one, duplicated or damaged
    task automatic send_datagram();
        iprx_hdr_t   frags[$];
        iprx_hdr_t   tmp;
        bit          inner;
        bit          more;
        logic [15:0] ident;
        logic [7:0]  proto;
        logic [3:0]  ihl;
        logic [15:0] plen;
        logic [12:0] off_units;
        int          count;
        int          unit_cap;
        int          pick;
        inner = $urandom_range(0, 1);
        ident = 16'($urandom);
        proto = pick_protocol();
        ihl = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(5, 15)) : 4'd5;
        count = $urandom_range(2, 6);
        unit_cap = ($urandom_range(0, 7) == 0) ? 2000 : 8;
        off_units = '0;
        for (int i = 0; i < count; i++)
        begin
            more = (i != count - 1);
            if (more)
                plen = 16'(8 * $urandom_range(1, unit_cap));
            else
                plen = 16'($urandom_range(0, 200));
            frags.push_back(build_header(inner, ident, {2'($urandom), more, off_units},
                                         proto, ihl, plen));
            off_units = off_units + 13'(plen >> 3);
        end
        case ($urandom_range(0, 9))
            5, 6:
                for (int i = frags.size() - 1; i > 0; i--)
                begin
                    pick = $urandom_range(0, i);
                    tmp = frags[i];
                    frags[i] = frags[pick];
                    frags[pick] = tmp;
                end
            7: frags.delete($urandom_range(0, frags.size() - 1));
            8:
            begin
                pick = $urandom_range(0, frags.size() - 1);
                frags.push_back(frags[pick]);
            end
            9:
            begin
                pick = $urandom_range(0, frags.size() - 1);
                frags[pick] = damage(frags[pick]);
            end
            default: ;
        endcase
        foreach (frags[i])
            send_header(frags[i]);
    endtask

    task automatic send_mixed_traffic(input int item_goal);
        int first;
        first = items_sent;
        while (items_sent - first < item_goal)
        begin
            case ($urandom_range(0, 19))
                0, 1, 2: send_header(noise_header());
                3, 4, 5:
                    send_header(build_header($urandom_range(0, 1), 16'($urandom),
                                             {2'($urandom), 14'h0}, pick_protocol(),
                                             4'($urandom_range(5, 15)),
                                             16'($urandom_range(0, 1500))));
                default: send_datagram();
            endcase
        end
    endtask

    // registers still at reset, order of the filter checks
    task automatic test_filter_checks();
        iprx_hdr_t h;
        send_header(build_header(1'b0, 16'h0000, 16'h0000, UDP_PROTOCOL, 4'd5, 16'd0));
        send_header(build_header(1'b1, 16'h1234, 16'h0000, IPIP_PROTOCOL, 4'd5, 16'd100));
        send_header(build_header(1'b0, 16'hffff, 16'h4000, 8'd6, 4'd15, 16'd40));
        h = build_header(1'b0, 16'h0042, 16'h0000, UDP_PROTOCOL, 4'd5, 16'd8);
        h.src_addr = 32'h0000_0001;
        h.header_checksum = header_checksum_of(h);
        send_header(h);
        h.header_checksum = h.header_checksum ^ 16'h0001;
        send_header(h);
        h.frame_length = h.total_length + 16'd1;
        send_header(h);
        wait_drained();
    endtask

    // all-ones addresses: short header, wrap, oversize, late fragment, duplicates
    task automatic test_fragment_corners();
        iprx_hdr_t h;
        set_addresses(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        send_header(build_header(1'b0, 16'h0100, 16'h0000, UDP_PROTOCOL, 4'd0, 16'd20));
        h = build_header(1'b0, 16'h00a0, 16'h0000, UDP_PROTOCOL, 4'd2, 16'd0);
        h.total_length = 16'd4;
        h.frame_length = 16'd4;
        h.header_checksum = header_checksum_of(h);
        send_header(h);
        h.identification = 16'h0007;
        h.flags_fragment = MF_MASK | 16'd1;
        h.header_checksum = header_checksum_of(h);
        send_header(h);
        send_header(build_header(1'b0, 16'h0007, 16'h1fff, UDP_PROTOCOL, 4'd5, 16'd8));
        send_header(build_header(1'b0, 16'h0006, 16'h1ffe, UDP_PROTOCOL, 4'd5, 16'd15));
        send_header(build_header(1'b0, 16'h0001, MF_MASK, UDP_PROTOCOL, 4'd5, 16'd0));
        send_header(build_header(1'b0, 16'h0003, 16'd2, IPIP_PROTOCOL, 4'd5, 16'd16));
        send_header(build_header(1'b0, 16'h0003, MF_MASK | 16'd5, IPIP_PROTOCOL, 4'd5,
                                 16'd8));
        send_header(build_header(1'b0, 16'h0003, 16'd3, IPIP_PROTOCOL, 4'd5, 16'd0));
        send_header(build_header(1'b0, 16'h0004, MF_MASK, UDP_PROTOCOL, 4'd5, 16'd16));
        send_header(build_header(1'b0, 16'h0004, MF_MASK, UDP_PROTOCOL, 4'd5, 16'd16));
        send_header(build_header(1'b0, 16'h0004, 16'd2, UDP_PROTOCOL, 4'd5, 16'd16));
        send_header(build_header(1'b0, 16'h0005, MF_MASK, UDP_PROTOCOL, 4'd5, 16'd24));
        send_header(build_header(1'b0, 16'h0005, 16'd3, UDP_PROTOCOL, 4'd5, 16'd10));
        send_header(build_header(1'b1, 16'h0008, 16'hc000, UDP_PROTOCOL, 4'd6, 16'd33));
        send_header('1);
        send_header('0);
        wait_drained();
    endtask

    task automatic test_random_traffic();
        set_addresses($urandom, $urandom, $urandom, $urandom);
        send_mixed_traffic(450);
        set_addresses($urandom, $urandom, $urandom, $urandom);
        send_mixed_traffic(450);
        wait_drained();
    endtask

    // result side held off while headers keep coming, then a full drain
    task automatic test_output_backpressure();
        set_addresses(32'h0, 32'hffff_ffff, 32'hffff_ffff, 32'h0);
        tx_idle_on = 1'b0;
        hold_request = 1'b1;
        send_mixed_traffic(60);
        wait_drained();
        tx_idle_on = 1'b1;
        send_mixed_traffic(30);
        wait_drained();
    endtask

    task automatic test_steady_stream();
        set_addresses($urandom, $urandom, $urandom, $urandom);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        send_mixed_traffic(100);
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        hdr_ch.valid = 1'b0;
        hdr_ch.data = '0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_filter_checks();
        test_fragment_corners();
        test_random_traffic();
        test_output_backpressure();
        test_steady_stream();
        hdr_ch.valid = 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("ipv4_rx_filter_reassembly_tracker verification clean");
        else
            $display("ipv4_rx_filter_reassembly_tracker verification failed");
        $finish;
    end

endmodule

// File: ipv4_rx_filter_reassembly_tracker.f
+incdir+rtl
rtl/iprx_pkg.sv
rtl/iprx_if.sv
rtl/iprx_hdr_check.sv
rtl/iprx_slot_mem.sv
rtl/ipv4_rx_filter_reassembly_tracker.sv
bench/ipv4_rx_filter_reassembly_tracker_test.sv
